[src/cassette_tape_block_decoder_core_defines.svh]
// Assertion macros for the cassette tape block decoder.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef CASSETTE_TAPE_BLOCK_DECODER_CORE_DEFINES_SVH
`define CASSETTE_TAPE_BLOCK_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define CTBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define CTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define CTBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CTBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/ctbd_pkg.sv]
// Shared types and constants of the cassette tape block decoder.
// No dependencies; imported by the framer, the top level and the testbench.
`default_nettype none

package ctbd_pkg;

	// Register reset values and default framer leader length.
	localparam logic [7:0] LONG_THRESHOLD_RST = 8'd27;
	localparam logic [7:0] GLITCH_MIN_RST     = 8'd9;
	localparam logic       CHECK_ENABLE_RST   = 1'b1;
	localparam int         LEADER_MIN_DEF     = 8;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LONG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_GLITCH_MIN     = 2'd1;
	localparam logic [1:0] CFG_CHECK_ENABLE   = 2'd2;

	// Output byte kinds.
	localparam logic [1:0] KIND_TYPE   = 2'd0;
	localparam logic [1:0] KIND_LENGTH = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	// Tape framing bytes.
	localparam logic [7:0] LEADER_BYTE = 8'h01;
	localparam logic [7:0] SYNC1_BYTE  = 8'h3C;
	localparam logic [7:0] SYNC2_BYTE  = 8'h5A;

	// One decoded bit from the run classifier.
	typedef struct packed {
		logic valid;
		logic value;
	} bit_ev_t;

	// One framer result request.
	typedef struct packed {
		logic       valid;
		logic [7:0] value;
		logic [1:0] kind;
		logic       last;
		logic       bad;
	} frame_res_t;

endpackage

`default_nettype wire

[src/ctbd_framer.sv]
// Byte assembler and block framer of the cassette tape block decoder.
// Depends on ctbd_pkg for the bit event and result types.
`default_nettype none

module ctbd_framer import ctbd_pkg::*; #(
	parameter int LEADER_MIN = LEADER_MIN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire bit_ev_t    bev,
	input  wire logic       check_enable,
	output frame_res_t      res
);

	typedef enum logic [7:0] {
		FS_HUNT   = 8'b0000_0001,
		FS_FIRST  = 8'b0000_0010,
		FS_LEADER = 8'b0000_0100,
		FS_SYNC2  = 8'b0000_1000,
		FS_TYPE   = 8'b0001_0000,
		FS_LENGTH = 8'b0010_0000,
		FS_DATA   = 8'b0100_0000,
		FS_CHECK  = 8'b1000_0000
	} frame_state_t;

	localparam logic [3:0] LEADER_LIM = 4'(LEADER_MIN);

	frame_state_t state_q, state_n;
	logic [7:0]   shift_q, shift_n;
	logic [2:0]   cnt_q, cnt_n;
	logic [3:0]   lead_q, lead_n;
	logic [7:0]   left_q, left_n;
	logic [7:0]   sum_q, sum_n;
	logic [7:0]   left_dec;
	logic [7:0]   len_minus2;
	logic [7:0]   sum_add;

	assign left_dec   = left_q - 8'd1;
	assign len_minus2 = shift_n - 8'd2;
	assign sum_add    = sum_q + shift_n;

	// Bit packing and per-byte framing decisions.
	always_comb begin
		state_n = state_q;
		shift_n = shift_q;
		cnt_n   = cnt_q;
		lead_n  = lead_q;
		left_n  = left_q;
		sum_n   = sum_q;
		res     = '0;
		if (bev.valid) begin
			if (state_q == FS_HUNT) begin
				if (bev.value) begin
					state_n = FS_FIRST;
					cnt_n   = 3'd0;
					shift_n = 8'd0;
				end
			end else begin
				shift_n = {shift_q[6:0], bev.value};
				cnt_n   = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					res.value = shift_n;
					unique case (state_q)
						FS_FIRST: begin
							if (shift_n == LEADER_BYTE) begin
								lead_n  = 4'd1;
								state_n = FS_LEADER;
							end else begin
								state_n = FS_HUNT;
							end
						end
						FS_LEADER: begin
							if (shift_n == LEADER_BYTE) begin
								if (lead_q != 4'hF) lead_n = lead_q + 4'd1;
							end else if (lead_q > LEADER_LIM && shift_n == SYNC1_BYTE) begin
								state_n = FS_SYNC2;
							end else begin
								state_n = FS_HUNT;
							end
						end
						FS_SYNC2: begin
							state_n = (shift_n == SYNC2_BYTE) ? FS_TYPE : FS_HUNT;
						end
						FS_TYPE: begin
							sum_n     = 8'd0;
							state_n   = FS_LENGTH;
							res.valid = 1'b1;
							res.kind  = KIND_TYPE;
						end
						FS_LENGTH: begin
							left_n    = len_minus2;
							state_n   = (len_minus2 == 8'd0) ? FS_CHECK : FS_DATA;
							res.valid = 1'b1;
							res.kind  = KIND_LENGTH;
						end
						FS_DATA: begin
							sum_n     = sum_add;
							left_n    = left_dec;
							if (left_dec == 8'd0) state_n = FS_CHECK;
							res.valid = 1'b1;
							res.kind  = KIND_DATA;
						end
						FS_CHECK: begin
							state_n   = FS_HUNT;
							res.valid = 1'b1;
							res.kind  = KIND_CHECK;
							res.last  = 1'b1;
							res.bad   = check_enable && (sum_add != 8'd0);
						end
						default: begin
							state_n = FS_HUNT;
						end
					endcase
				end
			end
		end
	end

	// Framer state advances only when the pipeline stage advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_HUNT;
			shift_q <= 8'd0;
			cnt_q   <= 3'd0;
			lead_q  <= 4'd0;
			left_q  <= 8'd0;
			sum_q   <= 8'd0;
		end else if (en) begin
			state_q <= state_n;
			shift_q <= shift_n;
			cnt_q   <= cnt_n;
			lead_q  <= lead_n;
			left_q  <= left_n;
			sum_q   <= sum_n;
		end
	end

endmodule

`default_nettype wire

[src/cassette_tape_block_decoder_core.sv]
// Top level of the cassette tape block decoder: input stage, run classifier,
// output register. Depends on ctbd_pkg, ctbd_framer and the assertion macros.
//
// Usage:
//   The input channel (in_valid, in_stall, sample) takes one 8-bit audio
//   sample per request; a sample above 127 is a high level. The output channel
//   (out_valid, out_stall, byte_value, byte_kind, block_end, checksum_bad)
//   carries one decoded block byte per request; most samples give none.
//   Configuration is written through cfg_we, cfg_index and cfg_data while the
//   block is idle; index 0 is the long run threshold, 1 the glitch minimum,
//   2 the checksum enable.
//   An accepted sample is held in the input stage; its byte, if any, is loaded
//   into the output register when that stage advances.
//   Throughput: one sample per cycle unless out_stall holds the output, set by
//   the single registered stage that updates the run counter and framer state.
//   Reset clears the level tracker, run counter, framer and registers to
//   their defaults; no request is pending afterwards.
//   While the output is held by out_stall, the sample in the input stage
//   waits and in_stall rises; an empty input stage still takes a sample.
`default_nettype none
`include "cassette_tape_block_decoder_core_defines.svh"

module cassette_tape_block_decoder_core import ctbd_pkg::*; #(
	parameter int LEADER_MIN = LEADER_MIN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] sample,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      byte_value,
	output logic [1:0]      byte_kind,
	output logic            block_end,
	output logic            checksum_bad
);

	logic       long_thr_q;
	logic [7:0] long_threshold_q;
	logic [7:0] glitch_min_q;
	logic       check_enable_q;
	logic       s1_valid_q;
	logic       s1_level_q;
	logic       level_q;
	logic [7:0] run_q;
	logic       half_q;
	logic       adv;
	logic       same;
	logic       kept;
	logic       half_n;
	bit_ev_t    bev;
	frame_res_t res;

	assign long_thr_q = run_q > long_threshold_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_threshold_q <= LONG_THRESHOLD_RST;
			glitch_min_q     <= GLITCH_MIN_RST;
			check_enable_q   <= CHECK_ENABLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LONG_THRESHOLD: long_threshold_q <= cfg_data;
				CFG_GLITCH_MIN:     glitch_min_q     <= cfg_data;
				CFG_CHECK_ENABLE:   check_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The stage advances when the output register is empty or being drained.
	assign adv      = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall = s1_valid_q && out_valid && out_stall;

	// Input stage keeps only the level of the sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) s1_level_q <= sample[7];
	end

	// Run classification: a level change ends the run that was counting.
	assign same = (s1_level_q == level_q);
	assign kept = !same && (run_q != 8'd0) && (run_q >= glitch_min_q);

	always_comb begin
		bev    = '0;
		half_n = half_q;
		if (kept) begin
			if (half_q) begin
				half_n    = 1'b0;
				bev.valid = 1'b1;
				bev.value = 1'b1;
			end else if (long_thr_q) begin
				bev.valid = 1'b1;
				bev.value = 1'b0;
			end else begin
				half_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			run_q   <= 8'd0;
			half_q  <= 1'b0;
		end else if (adv) begin
			half_q <= half_n;
			if (same) begin
				if (run_q != 8'hFF) run_q <= run_q + 8'd1;
			end else begin
				level_q <= s1_level_q;
				run_q   <= 8'd1;
			end
		end
	end

	ctbd_framer #(
		.LEADER_MIN(LEADER_MIN)
	) u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.bev         (bev),
		.check_enable(check_enable_q),
		.res         (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res.valid;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			byte_value   <= res.value;
			byte_kind    <= res.kind;
			block_end    <= res.last;
			checksum_bad <= res.bad;
		end
	end

	// Checks on the stage and result logic.
	`CTBD_ASSERT_IMPLY(a_bad_only_on_end, clk, arst_n, out_valid && checksum_bad, block_end)
	`CTBD_ASSERT_IMPLY(a_end_is_check, clk, arst_n, out_valid, block_end == (byte_kind == KIND_CHECK))
	`CTBD_ASSERT_NEXT(a_result_needs_item, clk, arst_n, !s1_valid_q && !out_valid, !out_valid)
	`CTBD_ASSERT_IMPLY(a_stall_when_full, clk, arst_n, in_stall, s1_valid_q && out_valid)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the cassette tape block decoder core.
// Feeds synthesized tape audio, predicts decoded block bytes and compares them.
// Depends on ctbd_pkg and cassette_tape_block_decoder_core.
`timescale 1ns / 1ps

module tb_top;
	import ctbd_pkg::*;

	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// Framer states of the predictor.
	typedef enum logic [2:0] {
		ST_HUNT, ST_FIRST, ST_LEADER, ST_SYNC2, ST_TYPE, ST_LENGTH, ST_DATA, ST_CHECK
	} tape_st_e;

	// One decoded block byte as it should appear on the output.
	typedef struct packed {
		logic [7:0] value;
		logic [1:0] kind;
		logic       last;
		logic       bad;
	} tape_byte_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       cfg_we       = 1'b0;
	logic [1:0] cfg_index    = CFG_LONG_THRESHOLD;
	logic [7:0] cfg_data     = 8'd0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] sample       = 8'd0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] byte_value;
	logic [1:0] byte_kind;
	logic       block_end;
	logic       checksum_bad;

	// Pending audio samples and the bytes they are predicted to decode to.
	logic [7:0] samples_q[$];
	tape_byte_t want_bytes[$];
	tape_byte_t want;

	// Predictor copy of the registers and of the decoder state.
	logic [7:0] cfg_long   = LONG_THRESHOLD_RST;
	logic [7:0] cfg_glitch = GLITCH_MIN_RST;
	logic       cfg_chk    = CHECK_ENABLE_RST;
	logic       lvl        = 1'b0;
	logic [7:0] run_len    = 8'd0;
	logic       half       = 1'b0;
	logic [7:0] shreg      = 8'd0;
	logic [3:0] nbits      = 4'd0;
	tape_st_e   fst        = ST_HUNT;
	logic [3:0] lead_cnt   = 4'd0;
	logic [7:0] left       = 8'd0;
	logic [7:0] blk_sum    = 8'd0;

	// Generator level of the last queued sample.
	logic       gen_lvl    = 1'b0;
	bit         calm       = 1'b0;

	int n_fail    = 0;
	int n_samples = 0;
	int n_bytes   = 0;
	int n_checks  = 0;
	int n_flagged = 0;
	int quiet     = 0;

	cassette_tape_block_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_value(byte_value),
		.byte_kind(byte_kind),
		.block_end(block_end),
		.checksum_bad(checksum_bad)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Framer: leader and sync hunting, then type, length, data and checksum bytes.
	function automatic void frame_byte(input logic [7:0] b);
		case (fst)
			ST_FIRST: begin
				if (b == LEADER_BYTE) begin
					lead_cnt = 4'd1;
					fst = ST_LEADER;
				end else
					fst = ST_HUNT;
			end
			ST_LEADER: begin
				if (b == LEADER_BYTE) begin
					if (lead_cnt != 4'd15)
						lead_cnt = lead_cnt + 4'd1;
				end else if (lead_cnt > LEADER_MIN_DEF && b == SYNC1_BYTE)
					fst = ST_SYNC2;
				else
					fst = ST_HUNT;
			end
			ST_SYNC2: fst = (b == SYNC2_BYTE) ? ST_TYPE : ST_HUNT;
			ST_TYPE: begin
				blk_sum = 8'd0;
				fst = ST_LENGTH;
				want_bytes.push_back({b, KIND_TYPE, 1'b0, 1'b0});
			end
			ST_LENGTH: begin
				left = b - 8'd2;
				fst = (left == 8'd0) ? ST_CHECK : ST_DATA;
				want_bytes.push_back({b, KIND_LENGTH, 1'b0, 1'b0});
			end
			ST_DATA: begin
				blk_sum = blk_sum + b;
				left = left - 8'd1;
				if (left == 8'd0)
					fst = ST_CHECK;
				want_bytes.push_back({b, KIND_DATA, 1'b0, 1'b0});
			end
			ST_CHECK: begin
				want_bytes.push_back({b, KIND_CHECK, 1'b1,
					cfg_chk && (8'(blk_sum + b) != 8'd0)});
				fst = ST_HUNT;
			end
			default: ;
		endcase
	endfunction

	// Bit assembly, MSB first; while hunting only a one bit starts a byte frame.
	function automatic void frame_bit(input logic b);
		if (fst == ST_HUNT) begin
			if (b) begin
				fst = ST_FIRST;
				nbits = 4'd0;
				shreg = 8'd0;
			end
		end else begin
			shreg = {shreg[6:0], b};
			nbits = nbits + 4'd1;
			if (nbits == 4'd8) begin
				nbits = 4'd0;
				frame_byte(shreg);
			end
		end
	endfunction

	// A finished run: glitches are dropped, a pending half pairs with any kept run.
	function automatic void run_done(input logic [7:0] len);
		if (len == 8'd0 || len < cfg_glitch)
			return;
		if (half) begin
			half = 1'b0;
			frame_bit(1'b1);
		end else if (len > cfg_long)
			frame_bit(1'b0);
		else
			half = 1'b1;
	endfunction

	// Per-sample update of the level tracker and run counter.
	function automatic void decode_sample(input logic [7:0] smp);
		logic [7:0] done;
		if (smp[7] == lvl) begin
			if (run_len != 8'hff)
				run_len = run_len + 8'd1;
		end else begin
			done = run_len;
			lvl = smp[7];
			run_len = 8'd1;
			run_done(done);
		end
	endfunction

	function automatic logic [7:0] level_sample(input logic hi);
		return hi ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127, 0));
	endfunction

	// Queue one run of the opposite level.
	function automatic void put_run(input int len);
		gen_lvl = !gen_lvl;
		repeat (len) samples_q.push_back(level_sample(gen_lvl));
	endfunction

	// A tape run, sometimes preceded by a glitch that the decoder must drop.
	function automatic void tape_run(input int len);
		if (cfg_glitch > 8'd1 && $urandom_range(9) == 0)
			put_run($urandom_range(cfg_glitch - 1, 1));
		put_run(len);
	endfunction

	function automatic int short_run();
		int lo, hi;
		lo = (cfg_glitch > 8'd1) ? cfg_glitch : 1;
		hi = (cfg_long > lo + 8) ? lo + 8 : cfg_long;
		return $urandom_range(hi, lo);
	endfunction

	function automatic int long_run();
		int lo, hi;
		lo = cfg_long + 1;
		if (cfg_glitch > lo)
			lo = cfg_glitch;
		hi = (lo + 6 > 255) ? 255 : lo + 6;
		return $urandom_range(hi, lo);
	endfunction

	// A one bit is two kept runs, the second of any length; a zero bit is one long run.
	function automatic void send_bit(input logic b);
		if (b) begin
			tape_run(short_run());
			tape_run(($urandom_range(7) == 0) ? long_run() : short_run());
		end else
			tape_run(long_run());
	endfunction

	function automatic void send_byte(input logic [7:0] v);
		for (int i = 7; i >= 0; i--)
			send_bit(v[i]);
	endfunction

	function automatic void send_noise(input int n);
		logic [7:0] s;
		repeat (n) begin
			s = 8'($urandom);
			gen_lvl = s[7];
			samples_q.push_back(s);
		end
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] v);
		logic [7:0] r;
		do
			r = 8'($urandom);
		while (r == v);
		return r;
	endfunction

	// One tape block: zero bits to realign, a start bit, leader, sync, header, data, checksum.
	function automatic void send_block(input int lead, input logic [7:0] sync_a,
			input logic [7:0] sync_b, input logic [7:0] len_byte, input logic sum_ok);
		logic [7:0] sum, d;
		int ndata;
		sum = 8'd0;
		ndata = 8'(len_byte - 8'd2);
		repeat (16) send_bit(1'b0);
		send_bit(1'b1);
		repeat (lead) send_byte(LEADER_BYTE);
		send_byte(sync_a);
		send_byte(sync_b);
		send_byte(8'($urandom));
		send_byte(len_byte);
		repeat (ndata) begin
			d = 8'($urandom);
			sum = sum + d;
			send_byte(d);
		end
		d = 8'd0 - sum;
		if (!sum_ok)
			d = d + 8'($urandom_range(255, 1));
		send_byte(d);
	endfunction

	// Wait until every sample is taken and every predicted byte has arrived.
	task automatic drain();
		do
			@(negedge clk);
		while (samples_q.size() != 0 || in_valid || want_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LONG_THRESHOLD: cfg_long = val;
			CFG_GLITCH_MIN:     cfg_glitch = val;
			CFG_CHECK_ENABLE:   cfg_chk = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] lng, input logic [7:0] gl, input logic chk);
		cfg_write(CFG_LONG_THRESHOLD, lng);
		cfg_write(CFG_GLITCH_MIN, gl);
		cfg_write(CFG_CHECK_ENABLE, {7'd0, chk});
	endtask

	// Mostly well-formed blocks with random content, some broken framing and noise.
	task automatic random_phase(input logic [7:0] lng, input logic [7:0] gl, input logic chk,
			input int pieces, input bit steady);
		int r, lead;
		set_config(lng, gl, chk);
		calm = steady;
		repeat (pieces) begin
			r = $urandom_range(99);
			if (r < 72) begin
				lead = ($urandom_range(9) == 0) ? $urandom_range(16, 12) : $urandom_range(11, 9);
				send_block(lead, SYNC1_BYTE, SYNC2_BYTE, 8'($urandom_range(8, 2)),
					$urandom_range(3) != 0);
			end else if (r < 88) begin
				case ($urandom_range(2))
					0: send_block($urandom_range(8, 1), SYNC1_BYTE, SYNC2_BYTE, 8'd4, 1'b1);
					1: send_block(10, other_than(SYNC1_BYTE), SYNC2_BYTE, 8'd4, 1'b1);
					default: send_block(10, SYNC1_BYTE, other_than(SYNC2_BYTE), 8'd4, 1'b1);
				endcase
			end else if ($urandom_range(1) == 0)
				send_noise($urandom_range(60, 10));
			else
				repeat ($urandom_range(12, 3)) tape_run($urandom_range(40, 1));
		end
		drain();
		calm = 1'b0;
	endtask

	// Sample driver: takes requests from the queue, predicts on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_sample(sample);
				n_samples++;
			end
			if (!in_valid || !in_stall) begin
				if (samples_q.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
					in_valid <= 1'b1;
					sample <= samples_q.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Byte monitor: compares each accepted request with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (want_bytes.size() == 0) begin
					$error("unexpected byte: byte_value %0h with no byte predicted", byte_value);
					n_fail++;
				end else begin
					want = want_bytes.pop_front();
					if (byte_value !== want.value) begin
						$error("byte_value: expected %0h, got %0h", want.value, byte_value);
						n_fail++;
					end
					if (byte_kind !== want.kind) begin
						$error("byte_kind: expected %0d, got %0d", want.kind, byte_kind);
						n_fail++;
					end
					if (block_end !== want.last) begin
						$error("block_end: expected %0b, got %0b", want.last, block_end);
						n_fail++;
					end
					if (checksum_bad !== want.bad) begin
						$error("checksum_bad: expected %0b, got %0b", want.bad, checksum_bad);
						n_fail++;
					end
				end
				n_bytes++;
				if (block_end) begin
					n_checks++;
					if (checksum_bad)
						n_flagged++;
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 34);
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else if (quiet == WATCHDOG_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	// Stimulus sequence: directed phases first, then random phases.
	initial begin
		logic [7:0] lng, gl;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: a first sample that ends an empty run, a run that saturates
		// the counter, a leader long enough to saturate its count, and no data bytes.
		put_run(300);
		send_block(17, SYNC1_BYTE, SYNC2_BYTE, 8'd2, 1'b1);
		drain();

		// Shortest runs with checking off: an unflagged bad checksum, a maximal data
		// length, a leader one byte too short and both kinds of failed sync.
		set_config(8'd1, 8'd1, 1'b0);
		send_block(9, SYNC1_BYTE, SYNC2_BYTE, 8'd5, 1'b0);
		send_block(10, SYNC1_BYTE, SYNC2_BYTE, 8'd1, 1'b1);
		send_block(8, SYNC1_BYTE, SYNC2_BYTE, 8'd4, 1'b1);
		send_block(10, 8'h3B, SYNC2_BYTE, 8'd4, 1'b1);
		send_block(10, SYNC1_BYTE, 8'h5B, 8'd4, 1'b1);
		drain();

		// Widest thresholds: only saturated runs are kept and all of them are halves.
		set_config(8'd255, 8'd255, 1'b1);
		put_run(300);
		put_run(254);
		put_run(300);
		put_run(255);
		put_run(260);
		put_run(1);
		drain();

		// Zero thresholds: nothing is dropped and every kept run is a zero bit.
		set_config(8'd0, 8'd0, 1'b0);
		send_noise(80);
		drain();

		// No glitch filtering, a length byte that wraps, and a flagged checksum.
		set_config(8'd2, 8'd0, 1'b1);
		send_block(9, SYNC1_BYTE, SYNC2_BYTE, 8'd0, 1'b1);
		send_block(12, SYNC1_BYTE, SYNC2_BYTE, 8'd3, 1'b0);
		drain();

		random_phase(8'd3, 8'd2, 1'b1, 8, 1'b0);
		random_phase(8'd4, 8'd3, 1'b1, 8, 1'b1);
		random_phase(LONG_THRESHOLD_RST, GLITCH_MIN_RST, CHECK_ENABLE_RST, 2, 1'b0);
		lng = 8'($urandom_range(12, 2));
		gl = 8'($urandom_range(lng, 1));
		random_phase(lng, gl, 1'b0, 8, 1'b0);
		lng = 8'($urandom_range(12, 2));
		gl = 8'($urandom_range(lng, 1));
		random_phase(lng, gl, 1'b1, 8, 1'b0);

		if (want_bytes.size() != 0) begin
			$error("%0d predicted bytes never arrived", want_bytes.size());
			n_fail++;
		end
		$display("Run covered %0d samples over several threshold settings and checked %0d bytes,",
			n_samples, n_bytes);
		$display("including %0d checksum bytes of which %0d were flagged bad.",
			n_checks, n_flagged);
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
